>>> hdl/ttc_pkg.sv
`default_nettype none

package ttc_pkg;

	// Sizing
	localparam int MAX_WEIGHTS = 64;
	localparam int WEIGHT_BITS = 16;
	localparam int CNT_W       = $clog2(MAX_WEIGHTS + 1);
	localparam int ADDR_W      = $clog2(MAX_WEIGHTS);
	localparam int CFG_W       = 22;
	localparam int THR_W       = 23;
	localparam int LOW_W       = 22;
	localparam int UP_W        = 21;
	localparam int CALC_W      = ((WEIGHT_BITS > THR_W) ? WEIGHT_BITS : THR_W) + 2;

	// Saturation limits
	localparam int THR_MAX = 2**(THR_W - 1) - 1;
	localparam int THR_MIN = -(2**(THR_W - 1));
	localparam int LOW_MIN = -(2**(LOW_W - 1));
	localparam int UP_MAX  = 2**UP_W - 1;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_ASSIGN = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Stack control from the update stage
	typedef struct packed {
		logic                   push;
		logic                   pop;
		logic [CNT_W-1:0]       count;
		logic [WEIGHT_BITS-1:0] wdata;
	} stk_ctl_t;

endpackage

`default_nettype wire

>>> hdl/threshold_test_conditioner.sv
// Channel    Handshake                 Payload
// ---------  ------------------------  -------------------------------------------
// item in    start (busy always low)   operation, weight, value
// result     done (one-cycle strobe)   threshold_now, lower_sum, upper_sum,
//                                      remaining, decided_pass, decided_fail, status
// config     start_threshold_we        start_threshold
//
// One item per cycle; an item is captured in the input register, and its result
// strobe comes from the result register after it. The rate is set by the
// single update stage holding the stack top and its prefetched under-entry in
// registers (at most one memory read or one write per cycle).
// arst_n clears the test (empty, bounds and threshold zero) and the config register.
// The receiver cannot stall; busy is never raised.
`default_nettype none

module threshold_test_conditioner (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [1:0]                        operation,
	input  wire logic signed [ttc_pkg::WEIGHT_BITS-1:0] weight,
	input  wire logic                              value,
	input  wire logic                              start_threshold_we,
	input  wire logic signed [ttc_pkg::CFG_W-1:0]  start_threshold,
	output logic                                   done,
	output logic signed [ttc_pkg::THR_W-1:0]       threshold_now,
	output logic signed [ttc_pkg::LOW_W-1:0]       lower_sum,
	output logic [ttc_pkg::UP_W-1:0]               upper_sum,
	output logic [ttc_pkg::CNT_W-1:0]              remaining,
	output logic                                   decided_pass,
	output logic                                   decided_fail,
	output logic [1:0]                             status
);
	import ttc_pkg::*;

	stk_ctl_t                      ctl;
	logic signed [WEIGHT_BITS-1:0] top;

	assign busy = 1'b0;

	ttc_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.operation     (operation),
		.weight        (weight),
		.value         (value),
		.cfg_we        (start_threshold_we),
		.cfg_data      (start_threshold),
		.top           (top),
		.ctl           (ctl),
		.done          (done),
		.threshold_now (threshold_now),
		.lower_sum     (lower_sum),
		.upper_sum     (upper_sum),
		.remaining     (remaining),
		.decided_pass  (decided_pass),
		.decided_fail  (decided_fail),
		.status        (status)
	);

	ttc_stack u_stack (
		.clk    (clk),
		.ctl    (ctl),
		.top    (top)
	);

	// A result only follows an item taken earlier, through the input and result registers
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 2))
		else $error("result without item");

	// Fill count stays within the store
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		remaining <= CNT_W'(MAX_WEIGHTS))
		else $error("remaining out of range");

	// Error status matches the fill count it reports
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_FULL)) |-> (remaining == CNT_W'(MAX_WEIGHTS)))
		else $error("full status with room left");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_EMPTY)) |-> (remaining == '0))
		else $error("empty status with weights left");

	// Stack is never pushed and popped together
	a_stk_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.push && ctl.pop))
		else $error("push and pop together");

endmodule

`default_nettype wire

>>> hdl/ttc_stack.sv
`default_nettype none

// Weight stack: top entry in a register, the entry below it prefetched from
// memory, so a pop needs no memory read in the same cycle.
module ttc_stack (
	input  wire logic                              clk,
	input  wire ttc_pkg::stk_ctl_t                 ctl,
	output logic signed [ttc_pkg::WEIGHT_BITS-1:0] top
);
	import ttc_pkg::*;

	logic [WEIGHT_BITS-1:0] mem [MAX_WEIGHTS];
	logic [WEIGHT_BITS-1:0] top_q;
	logic [WEIGHT_BITS-1:0] under_q;
	logic [CNT_W-1:0]       wr_cnt;
	logic [CNT_W-1:0]       rd_cnt;
	logic [ADDR_W-1:0]      wr_addr;
	logic [ADDR_W-1:0]      rd_addr;

	// Push spills the old top to slot count-1; after a pop the new
	// under-entry sits at slot count-3.
	assign wr_cnt  = ctl.count - CNT_W'(1);
	assign rd_cnt  = ctl.count - CNT_W'(3);
	assign wr_addr = wr_cnt[ADDR_W-1:0];
	assign rd_addr = rd_cnt[ADDR_W-1:0];

	// Memory write port
	always_ff @(posedge clk) begin
		if (ctl.push && (ctl.count != '0)) begin
			mem[wr_addr] <= top_q;
		end
	end

	// Top and prefetched under-entry; no reset, read only below the count
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			top_q   <= ctl.wdata;
			under_q <= top_q;
		end else if (ctl.pop) begin
			top_q   <= under_q;
			under_q <= mem[rd_addr];
		end
	end

	assign top = signed'(top_q);

endmodule

`default_nettype wire

>>> hdl/ttc_core.sv
`default_nettype none

// Input register, single-pass state update and result flags.
module ttc_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [1:0]                        operation,
	input  wire logic signed [ttc_pkg::WEIGHT_BITS-1:0] weight,
	input  wire logic                              value,
	input  wire logic                              cfg_we,
	input  wire logic signed [ttc_pkg::CFG_W-1:0]  cfg_data,
	input  wire logic signed [ttc_pkg::WEIGHT_BITS-1:0] top,
	output ttc_pkg::stk_ctl_t                      ctl,
	output logic                                   done,
	output logic signed [ttc_pkg::THR_W-1:0]       threshold_now,
	output logic signed [ttc_pkg::LOW_W-1:0]       lower_sum,
	output logic [ttc_pkg::UP_W-1:0]               upper_sum,
	output logic [ttc_pkg::CNT_W-1:0]              remaining,
	output logic                                   decided_pass,
	output logic                                   decided_fail,
	output logic [1:0]                             status
);
	import ttc_pkg::*;

	function automatic logic signed [CALC_W-1:0] clamp(
		input logic signed [CALC_W-1:0] v,
		input logic signed [CALC_W-1:0] lo,
		input logic signed [CALC_W-1:0] hi
	);
		logic signed [CALC_W-1:0] r;
		r = v;
		if (v < lo) r = lo;
		else if (v > hi) r = hi;
		return r;
	endfunction

	// Input stage
	logic                          valid_s1;
	logic [1:0]                    op_s1;
	logic signed [WEIGHT_BITS-1:0] weight_s1;
	logic                          value_s1;

	// Test state
	logic signed [CFG_W-1:0] start_thr_q;
	logic [CNT_W-1:0]        cnt_q, cnt_d;
	logic signed [LOW_W-1:0] lower_q, lower_d;
	logic [UP_W-1:0]         upper_q, upper_d;
	logic signed [THR_W-1:0] thr_q, thr_d;
	status_t                 status_d;
	logic                    push, pop;

	// Result registers
	logic    done_q;
	logic    pass_q, fail_q;
	status_t status_q;

	logic signed [CALC_W-1:0] w_app, w_top, lower_x, upper_x, thr_x;
	logic signed [CALC_W-1:0] lower_nx, upper_nx, thr_nx;
	logic                     ordered;

	assign w_app   = CALC_W'(weight_s1);
	assign w_top   = CALC_W'(top);
	assign lower_x = CALC_W'(lower_q);
	assign upper_x = CALC_W'(signed'({1'b0, upper_q}));
	assign thr_x   = CALC_W'(thr_q);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_s1     <= operation;
			weight_s1 <= weight;
			value_s1  <= value;
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_thr_q <= '0;
		end else if (cfg_we) begin
			start_thr_q <= cfg_data;
		end
	end

	// Next state for the item in the input stage
	always_comb begin
		cnt_d    = cnt_q;
		lower_d  = lower_q;
		upper_d  = upper_q;
		thr_d    = thr_q;
		status_d = ST_OK;
		push     = 1'b0;
		pop      = 1'b0;
		case (op_s1)
			OP_CLEAR: begin
				cnt_d   = '0;
				lower_d = '0;
				upper_d = '0;
				thr_d   = THR_W'(start_thr_q);
			end
			OP_APPEND: begin
				if (cnt_q >= CNT_W'(MAX_WEIGHTS)) begin
					status_d = ST_FULL;
				end else begin
					push  = 1'b1;
					cnt_d = cnt_q + CNT_W'(1);
					if (w_app < 0) begin
						lower_d = LOW_W'(clamp(lower_x + w_app, CALC_W'(LOW_MIN), '0));
					end else if (w_app > 0) begin
						upper_d = UP_W'(clamp(upper_x + w_app, '0, CALC_W'(UP_MAX)));
					end
				end
			end
			OP_ASSIGN: begin
				if (cnt_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					pop   = 1'b1;
					cnt_d = cnt_q - CNT_W'(1);
					if (value_s1) begin
						thr_d = THR_W'(clamp(thr_x - w_top, CALC_W'(THR_MIN),
							CALC_W'(THR_MAX)));
					end
					if (w_top > 0) begin
						upper_d = UP_W'(clamp(upper_x - w_top, '0, CALC_W'(UP_MAX)));
					end else begin
						lower_d = LOW_W'(clamp(lower_x - w_top, CALC_W'(LOW_MIN), '0));
					end
				end
			end
			default: begin
				// unused code: state held, status ok
			end
		endcase
	end

	// Trivial pass / fail on the updated test
	assign lower_nx = CALC_W'(lower_d);
	assign upper_nx = CALC_W'(signed'({1'b0, upper_d}));
	assign thr_nx   = CALC_W'(thr_d);
	assign ordered  = lower_nx <= upper_nx;

	// Stack control
	always_comb begin
		ctl.push  = valid_s1 && push;
		ctl.pop   = valid_s1 && pop;
		ctl.count = cnt_q;
		ctl.wdata = weight_s1;
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			lower_q <= '0;
			upper_q <= '0;
			thr_q   <= '0;
		end else if (valid_s1) begin
			cnt_q   <= cnt_d;
			lower_q <= lower_d;
			upper_q <= upper_d;
			thr_q   <= thr_d;
		end
	end

	// Result strobe and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			pass_q   <= ordered && (thr_nx <= lower_nx);
			fail_q   <= ordered && (upper_nx < thr_nx);
			status_q <= status_d;
		end
	end

	// Numeric results come straight from the state registers
	assign done          = done_q;
	assign threshold_now = thr_q;
	assign lower_sum     = lower_q;
	assign upper_sum     = upper_q;
	assign remaining     = cnt_q;
	assign decided_pass  = pass_q;
	assign decided_fail  = fail_q;
	assign status        = status_q;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ttc_pkg::*;

	// Operation code 3 is not decoded by the block
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int LATENCY_PAD = 4;

	typedef struct packed {
		logic signed [THR_W-1:0] thr;
		logic signed [LOW_W-1:0] lower;
		logic [UP_W-1:0]         upper;
		logic [CNT_W-1:0]        remaining;
		logic                    pass;
		logic                    fail;
		status_t                 status;
	} test_result_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic [1:0]                    operation;
	logic signed [WEIGHT_BITS-1:0] weight;
	logic                          value;
	logic                          start_threshold_we;
	logic signed [CFG_W-1:0]       start_threshold;
	logic                          done;
	logic signed [THR_W-1:0]       threshold_now;
	logic signed [LOW_W-1:0]       lower_sum;
	logic [UP_W-1:0]               upper_sum;
	logic [CNT_W-1:0]              remaining;
	logic                          decided_pass;
	logic                          decided_fail;
	logic [1:0]                    status;

	threshold_test_conditioner dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.operation          (operation),
		.weight             (weight),
		.value              (value),
		.start_threshold_we (start_threshold_we),
		.start_threshold    (start_threshold),
		.done               (done),
		.threshold_now      (threshold_now),
		.lower_sum          (lower_sum),
		.upper_sum          (upper_sum),
		.remaining          (remaining),
		.decided_pass       (decided_pass),
		.decided_fail       (decided_fail),
		.status             (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the conditioned test
	logic signed [WEIGHT_BITS-1:0] held_weights [MAX_WEIGHTS];
	int     held_count;
	longint held_lower;
	longint held_upper;
	longint held_thr;
	longint cfg_thr;

	test_result_t pending_results [$];
	int mismatch_count;
	int idle_pct;

	function automatic longint sat(longint v, longint lo, longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic string fmt_result(test_result_t r);
		return $sformatf("thr=%0d lower=%0d upper=%0d rem=%0d p=%b f=%b st=%0d",
			r.thr, r.lower, r.upper, r.remaining, r.pass, r.fail, r.status);
	endfunction

	// Apply one item to the shadow test and queue the result it should give
	function automatic void condition_test(logic [1:0] op, logic signed [WEIGHT_BITS-1:0] w,
			logic v);
		test_result_t r;
		longint wt;
		status_t st;
		logic ordered;
		st = ST_OK;
		case (op)
			OP_CLEAR: begin
				held_count = 0;
				held_lower = 0;
				held_upper = 0;
				held_thr   = cfg_thr;
			end
			OP_APPEND: begin
				if (held_count >= MAX_WEIGHTS) begin
					st = ST_FULL;
				end else begin
					held_weights[held_count] = w;
					held_count++;
					wt = w;
					if (wt < 0)
						held_lower = sat(held_lower + wt, LOW_MIN, 0);
					else if (wt > 0)
						held_upper = sat(held_upper + wt, 0, UP_MAX);
				end
			end
			OP_ASSIGN: begin
				if (held_count == 0) begin
					st = ST_EMPTY;
				end else begin
					wt = held_weights[held_count - 1];
					if (v)
						held_thr = sat(held_thr - wt, THR_MIN, THR_MAX);
					// a zero weight sits with the lower bound
					if (wt > 0)
						held_upper = sat(held_upper - wt, 0, UP_MAX);
					else
						held_lower = sat(held_lower - wt, LOW_MIN, 0);
					held_count--;
				end
			end
			default: ;
		endcase
		ordered     = (held_lower <= held_upper);
		r.thr       = held_thr[THR_W-1:0];
		r.lower     = held_lower[LOW_W-1:0];
		r.upper     = held_upper[UP_W-1:0];
		r.remaining = held_count[CNT_W-1:0];
		r.pass      = ordered && (held_thr <= held_lower);
		r.fail      = ordered && (held_upper < held_thr);
		r.status    = st;
		pending_results.insert(pending_results.size(), r);
	endfunction

	// Result checker
	always @(posedge clk) begin
		test_result_t got;
		test_result_t want;
		if (arst_n && done) begin
			got = '{threshold_now, lower_sum, upper_sum, remaining,
				decided_pass, decided_fail, status_t'(status)};
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: %s", fmt_result(got));
			end else begin
				want = pending_results[0];
				pending_results.delete(0);
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result mismatch: exp %s / got %s",
							fmt_result(want), fmt_result(got));
				end
			end
		end
	end

	// Drive one item; entered and left at a falling edge
	task automatic send_item(input logic [1:0] op, input logic [WEIGHT_BITS-1:0] w,
			input logic v);
		while ($urandom_range(0, 99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start     = 1'b1;
		operation = op;
		weight    = w;
		value     = v;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
		condition_test(op, w, v);
	endtask

	task automatic wait_results();
		start = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (LATENCY_PAD) @(negedge clk);
	endtask

	task automatic set_start_threshold(input logic signed [CFG_W-1:0] thr);
		wait_results();
		start_threshold_we = 1'b1;
		start_threshold    = thr;
		@(negedge clk);
		start_threshold_we = 1'b0;
		cfg_thr            = thr;
	endtask

	function automatic logic [WEIGHT_BITS-1:0] pick_weight();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return WEIGHT_BITS'($urandom());
		endcase
	endfunction

	// Extremes, every operation, and the ignored and empty cases
	task automatic test_directed();
		send_item(OP_ASSIGN, WEIGHT_BITS'($urandom()), 1'b1);   // nothing to assign
		send_item(OP_UNUSED, WEIGHT_BITS'($urandom()), 1'b1);
		send_item(OP_CLEAR, 16'hffff, 1'b1);
		send_item(OP_APPEND, 16'h7fff, 1'b1);
		send_item(OP_APPEND, 16'h8000, 1'b1);
		send_item(OP_APPEND, 16'h0000, 1'b0);
		send_item(OP_APPEND, 16'h0001, 1'b0);
		send_item(OP_APPEND, 16'hffff, 1'b1);
		send_item(OP_ASSIGN, 16'h1234, 1'b0);
		send_item(OP_ASSIGN, 16'hffff, 1'b1);
		send_item(OP_ASSIGN, 16'h0000, 1'b1);     // zero weight
		send_item(OP_ASSIGN, 16'h8000, 1'b1);
		send_item(OP_ASSIGN, 16'h7fff, 1'b0);
		send_item(OP_ASSIGN, WEIGHT_BITS'($urandom()), 1'b0);   // store empty again
		send_item(OP_UNUSED, 16'h0000, 1'b0);
		send_item(OP_CLEAR, 16'h0000, 1'b0);
		send_item(OP_APPEND, 16'h5555, 1'b0);
		send_item(OP_APPEND, 16'haaaa, 1'b1);
		send_item(OP_ASSIGN, 16'h0000, 1'b1);
		send_item(OP_UNUSED, 16'hffff, 1'b1);
		send_item(OP_ASSIGN, 16'h0000, 1'b1);
		send_item(OP_CLEAR, 16'h5a5a, 1'b1);
	endtask

	// Fill past full, then assign past empty
	// mode 0: random weights, 1: all most negative, 2: all most positive
	task automatic test_fill_and_drain(input int mode);
		int n;
		logic [WEIGHT_BITS-1:0] w;
		send_item(OP_CLEAR, WEIGHT_BITS'($urandom()), 1'($urandom()));
		n = MAX_WEIGHTS + $urandom_range(1, 3);
		for (int i = 0; i < n; i++) begin
			case (mode)
				1: w = 16'h8000;
				2: w = 16'h7fff;
				default: w = pick_weight();
			endcase
			send_item(OP_APPEND, w, 1'($urandom()));
			if ($urandom_range(0, 19) == 0)
				send_item(OP_UNUSED, WEIGHT_BITS'($urandom()), 1'($urandom()));
		end
		for (int i = 0; i < n; i++)
			send_item(OP_ASSIGN, WEIGHT_BITS'($urandom()), 1'($urandom()));
	endtask

	// Append/assign pairs that drive the threshold into saturation
	task automatic test_saturation(input logic drive_up);
		logic [WEIGHT_BITS-1:0] w;
		send_item(OP_CLEAR, WEIGHT_BITS'($urandom()), 1'($urandom()));
		for (int i = 0; i < 80; i++) begin
			if (drive_up)
				w = WEIGHT_BITS'(-$urandom_range(30000, 32768));
			else
				w = WEIGHT_BITS'($urandom_range(30000, 32767));
			send_item(OP_APPEND, w, 1'($urandom()));
			send_item(OP_ASSIGN, WEIGHT_BITS'($urandom()), ($urandom_range(0, 9) != 0));
		end
	endtask

	// Random mix, biased toward appends and assigns
	task automatic test_random(input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 4)
				send_item(OP_CLEAR, WEIGHT_BITS'($urandom()), 1'($urandom()));
			else if (r < 50)
				send_item(OP_APPEND, pick_weight(), 1'($urandom()));
			else if (r < 92)
				send_item(OP_ASSIGN, WEIGHT_BITS'($urandom()), 1'($urandom()));
			else if (r < 96)
				send_item(OP_UNUSED, WEIGHT_BITS'($urandom()), 1'($urandom()));
			else
				send_item(2'($urandom()), WEIGHT_BITS'($urandom()), 1'($urandom()));
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		start              = 1'b0;
		operation          = OP_CLEAR;
		weight             = '0;
		value              = 1'b0;
		start_threshold_we = 1'b0;
		start_threshold    = '0;
		held_count         = 0;
		held_lower         = 0;
		held_upper         = 0;
		held_thr           = 0;
		cfg_thr            = 0;
		mismatch_count     = 0;
		idle_pct           = 26;
		foreach (held_weights[i])
			held_weights[i] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// sender idles often
		test_directed();
		set_start_threshold(CFG_W'($urandom()));
		test_fill_and_drain(0);
		set_start_threshold(-22'sd1);
		test_fill_and_drain(1);
		test_fill_and_drain(2);

		// sender idles more
		idle_pct = 49;
		set_start_threshold(22'sh1fffff);
		test_saturation(1'b1);
		set_start_threshold(22'sh200000);
		test_saturation(1'b0);

		// back to back
		idle_pct = 0;
		set_start_threshold(22'sd0);
		test_random(50);
		set_start_threshold(CFG_W'($urandom()));
		test_random(50);

		wait_results();
		if (mismatch_count == 0)
			$display("threshold_test_conditioner: match");
		else
			$display("threshold_test_conditioner: mismatch");
		$finish;
	end

	initial begin
		#2000000;
		$display("threshold_test_conditioner: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
